// ===== design/swec_pkg.sv =====
// Shared types and constants for the sliding-window event counter.
// No dependencies; used by swec_cell and sliding_window_event_counter_top.
package swec_pkg;

   localparam int DEPTH        = 64;
   localparam int TIME_BITS    = 32;
   localparam int WINDOW_BITS  = 32;
   localparam int COUNT_BITS   = $clog2(DEPTH + 1);
   localparam int RSP_BITS     = ((COUNT_BITS + 1 + 7) / 8) * 8;

   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(3000);

   // Control that the sequencer broadcasts to every cell.
   typedef struct packed {
      logic capture;   // latch the expiry compare against the incoming stamp
      logic shift;     // take stamp and valid from the younger neighbor
   } cell_ctrl_type;

endpackage

// ===== design/swec_cell.sv =====
// One cell of the timestamp chain: a stored stamp, its valid bit and its expiry flag.
// Depends on swec_pkg.
module swec_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  swec_pkg::cell_ctrl_type           ctrl,
   input  logic [swec_pkg::TIME_BITS-1:0]    new_stamp,
   input  logic [swec_pkg::WINDOW_BITS-1:0]  window_length,
   input  logic [swec_pkg::TIME_BITS-1:0]    stamp_in,
   input  logic                              valid_in,
   input  logic                              older_expired_in,
   output logic                              older_expired_out,
   output logic                              keep_out,
   output logic [swec_pkg::TIME_BITS-1:0]    stamp_out,
   output logic                              valid_out
);

   localparam int SUM_BITS = swec_pkg::TIME_BITS + 1;

   logic [swec_pkg::TIME_BITS-1:0] stamp_ff;
   logic                           valid_ff;
   logic                           expired_ff;
   logic                           expired_in;
   logic [SUM_BITS-1:0]            limit;

   // The stamp is past the window when stamp + window < new stamp, compared one bit wider than the stamp.
   assign limit      = {1'b0, stamp_ff} + SUM_BITS'(window_length);
   assign expired_in = valid_ff && (limit < {1'b0, new_stamp});

   // Every older entry and this one expired: this cell retires too.
   assign older_expired_out = older_expired_in && (!valid_ff || expired_ff);
   assign keep_out          = valid_ff && !(expired_ff && older_expired_in);
   assign stamp_out         = stamp_ff;
   assign valid_out         = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         expired_ff <= 1'b0;
      end else begin
         if (ctrl.capture) begin
            expired_ff <= expired_in;
         end
         if (ctrl.shift) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         stamp_ff <= stamp_in;
      end
   end

endmodule

// ===== design/sliding_window_event_counter_top.sv =====
// Sliding-window event counter: top level with the cell chain, sequencer and result register.
// Depends on swec_pkg and swec_cell.
//
// Each request transaction carries one event timestamp. The block keeps the last
// 64 timestamps in a chain of cells, newest in cell 0 and oldest at the highest
// valid cell. For each event it retires the unbroken run of expired entries at
// the oldest end (entry + window_length < timestamp, compared one bit wider than
// the timestamp), shifts the new timestamp into cell 0 and answers with the
// number of events held, the new one included. When all 64 entries are still
// inside the window the oldest falls off the end of the chain, overflow is set
// and the count stays at 64. An event first latches the per-cell expiry compares
// as it is accepted, then ripples the retire decision down the chain and shifts,
// then encodes the count into the result register (held while an earlier response
// waits on rsp_tready). The sequencer handles one event at a time; the result
// register lets the next event enter while a response transaction still waits on
// rsp_tready. window_length resets to 3000 and is written through csr_wr_en /
// csr_wr_data, by the user only while the block is idle; the block does not enforce it.
module sliding_window_event_counter_top (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration: window_length.
   input  logic                               csr_wr_en,
   input  logic [swec_pkg::WINDOW_BITS-1:0]   csr_wr_data,
   // Request: tdata = timestamp[31:0].
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swec_pkg::TIME_BITS-1:0]     req_tdata,
   // Response: tdata = recent_count[6:0], overflow[7].
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [swec_pkg::RSP_BITS-1:0]      rsp_tdata
);

   localparam int DEPTH = swec_pkg::DEPTH;
   localparam int CB    = swec_pkg::COUNT_BITS;

   // Sequencer phases.
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_SHIFT = 2'd1;
   localparam logic [1:0] PH_COUNT = 2'd2;

   logic [1:0]                         phase_ff;
   logic [1:0]                         phase_in;
   logic [swec_pkg::WINDOW_BITS-1:0]   window_ff;
   logic [swec_pkg::TIME_BITS-1:0]     stamp_ff;
   logic                               ovf_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [CB-1:0]                      rsp_count_ff;
   logic                               rsp_ovf_ff;

   swec_pkg::cell_ctrl_type            ctrl;
   logic                               req_fire;
   logic                               rsp_load;

   // Chain wiring, one entry per cell.
   logic [swec_pkg::TIME_BITS-1:0]     stamp_chain [DEPTH];
   logic [swec_pkg::TIME_BITS-1:0]     stamp_feed  [DEPTH];
   logic [DEPTH-1:0]                   valid_vec;
   logic [DEPTH-1:0]                   valid_feed;
   logic [DEPTH-1:0]                   keep_vec;
   logic [DEPTH-1:0]                   older_in;
   logic [DEPTH-1:0]                   older_out;
   logic [DEPTH-1:0]                   edge_vec;
   logic [CB-1:0]                      count_enc;

   assign req_tready = (phase_ff == PH_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (phase_ff == PH_COUNT) && (!rsp_valid_ff || rsp_tready);

   assign ctrl.capture = req_fire;
   assign ctrl.shift   = (phase_ff == PH_SHIFT);

   // Cell 0 takes the new event; every other cell takes its younger neighbor,
   // valid only if that neighbor survived expiry. The oldest cell sees nothing
   // older than itself, so its retire chain starts true.
   always_comb begin
      stamp_feed[0] = stamp_ff;
      valid_feed[0] = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
         stamp_feed[i] = stamp_chain[i-1];
         valid_feed[i] = keep_vec[i-1];
      end
      older_in[DEPTH-1] = 1'b1;
      for (int i = 0; i < DEPTH - 1; i++) begin
         older_in[i] = older_out[i+1];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      swec_cell u_cell (
         .clock             (clock),
         .reset             (reset),
         .ctrl              (ctrl),
         .new_stamp         (req_tdata),
         .window_length     (window_ff),
         .stamp_in          (stamp_feed[g]),
         .valid_in          (valid_feed[g]),
         .older_expired_in  (older_in[g]),
         .older_expired_out (older_out[g]),
         .keep_out          (keep_vec[g]),
         .stamp_out         (stamp_chain[g]),
         .valid_out         (valid_vec[g])
      );
   end

   // The valid bits always form a run from cell 0 up, so the count is the
   // position of the top valid cell plus one.
   assign edge_vec = valid_vec & ~{1'b0, valid_vec[DEPTH-1:1]};

   always_comb begin
      count_enc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (edge_vec[i]) begin
            count_enc = count_enc | CB'(i + 1);
         end
      end
   end

   always_comb begin
      case (phase_ff)
         PH_IDLE:  phase_in = req_fire ? PH_SHIFT : PH_IDLE;
         PH_SHIFT: phase_in = PH_COUNT;
         PH_COUNT: phase_in = rsp_load ? PH_IDLE : PH_COUNT;
         default:  phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         window_ff    <= swec_pkg::WINDOW_RESET;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stamp_ff <= req_tdata;
      end
      // A kept oldest cell means the chain was full: it falls off on the shift.
      if (ctrl.shift) begin
         ovf_ff <= keep_vec[DEPTH-1];
      end
      if (rsp_load) begin
         rsp_count_ff <= count_enc;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = swec_pkg::RSP_BITS'({rsp_ovf_ff, rsp_count_ff});

   // A new response appears only out of the count phase.
   a_rsp_from_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(phase_ff == PH_COUNT))
      else $error("response raised outside the count phase");

   // The valid bits stay a contiguous run starting at cell 0.
   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
      else $error("valid bits of the chain are not contiguous");

   // Overflow only comes with a full chain.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ovf_ff) |-> (rsp_count_ff == CB'(DEPTH)))
      else $error("overflow reported with a chain that is not full");

   // No event enters while one is still being processed.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready ##1 !req_tready)
      else $error("event accepted during a busy phase");

endmodule
